FILE: sv/vhfe_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and field extraction functions of the video header field extractor
package vhfe_pkg;

    // header kind codes
    localparam logic [2:0] KIND_SEQ_HDR = 3'd0;
    localparam logic [2:0] KIND_SEQ_EXT = 3'd1;
    localparam logic [2:0] KIND_GOP     = 3'd2;
    localparam logic [2:0] KIND_PIC_HDR = 3'd3;
    localparam logic [2:0] KIND_PIC_EXT = 3'd4;

    // field ids where the field order branches or ends
    localparam logic [4:0] FID_SEQ_HDR_LAST  = 5'd9;
    localparam logic [4:0] FID_SEQ_EXT_LAST  = 5'd11;
    localparam logic [4:0] FID_GOP_LAST      = 5'd2;
    localparam logic [4:0] FID_PIC_EXTRA_BIT = 5'd3;
    localparam logic [4:0] FID_PIC_NEXT_SC   = 5'd5;
    localparam logic [4:0] FID_PCE_COMPOSITE = 5'd16;
    localparam logic [4:0] FID_PCE_NEXT_SC   = 5'd22;

    // byte positions that close a header (index of the last byte)
    localparam logic [2:0] LAST_IDX_SEQ_HDR   = 3'd7;
    localparam logic [2:0] LAST_IDX_SEQ_EXT   = 3'd5;
    localparam logic [2:0] LAST_IDX_GOP       = 3'd3;
    localparam logic [2:0] LAST_IDX_PIC_SHORT = 3'd3;
    localparam logic [2:0] LAST_IDX_PIC_LONG  = 3'd4;
    localparam logic [2:0] LAST_IDX_PCE_SHORT = 3'd4;
    localparam logic [2:0] LAST_IDX_PCE_LONG  = 3'd6;

    localparam int VALUE_W = 25;

    typedef struct packed {
        logic [2:0] header_kind;
        logic       first_byte;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]         result_header_kind;
        logic [4:0]         field_id;
        logic [VALUE_W-1:0] field_value;
        logic               last_field;
    } t_out_beat;

    // header body bytes, element 0 is the first byte after the start code
    typedef logic [7:0][7:0] t_hdr_bytes;

    // one complete header handed from front to back
    typedef struct packed {
        logic [2:0] kind;
        t_hdr_bytes bytes;
    } t_job;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // true when the byte at position idx closes a header of this kind
    function automatic logic f_closes_header(input logic [2:0] kind, input logic [2:0] idx,
                                             input logic [7:0] data);
        logic done;
        done = 1'b0;
        case (kind)
            KIND_SEQ_HDR: done = (idx == LAST_IDX_SEQ_HDR);
            KIND_SEQ_EXT: done = (idx == LAST_IDX_SEQ_EXT);
            KIND_GOP:     done = (idx == LAST_IDX_GOP);
            KIND_PIC_HDR: done = ((idx == LAST_IDX_PIC_SHORT) && !data[2])
                              || (idx == LAST_IDX_PIC_LONG);
            KIND_PIC_EXT: done = ((idx == LAST_IDX_PCE_SHORT) && !data[6])
                              || (idx == LAST_IDX_PCE_LONG);
            default:      done = 1'b0;
        endcase
        return done;
    endfunction

    // id of the final field of a header kind
    function automatic logic [4:0] f_last_id(input logic [2:0] kind);
        logic [4:0] id;
        id = FID_PCE_NEXT_SC;
        case (kind)
            KIND_SEQ_HDR: id = FID_SEQ_HDR_LAST;
            KIND_SEQ_EXT: id = FID_SEQ_EXT_LAST;
            KIND_GOP:     id = FID_GOP_LAST;
            KIND_PIC_HDR: id = FID_PIC_NEXT_SC;
            default:      id = FID_PCE_NEXT_SC;
        endcase
        return id;
    endfunction

    // id of the field after fid, skipping fields whose flag is off
    function automatic logic [4:0] f_next_id(input logic [2:0] kind, input logic [4:0] fid,
                                             input t_hdr_bytes b);
        logic [4:0] nid;
        nid = fid + 5'd1;
        if (kind == KIND_PIC_HDR && fid == FID_PIC_EXTRA_BIT && !b[3][2]) begin
            nid = FID_PIC_NEXT_SC;
        end
        if (kind == KIND_PIC_EXT && fid == FID_PCE_COMPOSITE && !b[4][6]) begin
            nid = FID_PCE_NEXT_SC;
        end
        return nid;
    endfunction

    // value of one field, zero extended
    function automatic logic [VALUE_W-1:0] f_field_value(input logic [2:0] kind,
                                                         input logic [4:0] fid,
                                                         input t_hdr_bytes b);
        logic [VALUE_W-1:0] v;
        v = '0;
        case (kind)
            KIND_SEQ_HDR: begin
                case (fid)
                    5'd0:    v[11:0] = {b[0], b[1][7:4]};
                    5'd1:    v[11:0] = {b[1][3:0], b[2]};
                    5'd2:    v[3:0]  = b[3][7:4];
                    5'd3:    v[3:0]  = b[3][3:0];
                    5'd4:    v[17:0] = {b[4], b[5], b[6][7:6]};
                    5'd5:    v[0]    = b[6][5];
                    5'd6:    v[9:0]  = {b[6][4:0], b[7][7:3]};
                    5'd7:    v[0]    = b[7][2];
                    5'd8:    v[0]    = b[7][1];
                    5'd9:    v[0]    = b[7][0];
                    default: v = '0;
                endcase
            end
            KIND_SEQ_EXT: begin
                case (fid)
                    5'd0:    v[3:0]  = b[0][7:4];
                    5'd1:    v[7:0]  = {b[0][3:0], b[1][7:4]};
                    5'd2:    v[0]    = b[1][3];
                    5'd3:    v[1:0]  = b[1][2:1];
                    5'd4:    v[1:0]  = {b[1][0], b[2][7]};
                    5'd5:    v[1:0]  = b[2][6:5];
                    5'd6:    v[11:0] = {b[2][4:0], b[3][7:1]};
                    5'd7:    v[0]    = b[3][0];
                    5'd8:    v[7:0]  = b[4];
                    5'd9:    v[0]    = b[5][7];
                    5'd10:   v[1:0]  = b[5][6:5];
                    5'd11:   v[4:0]  = b[5][4:0];
                    default: v = '0;
                endcase
            end
            KIND_GOP: begin
                case (fid)
                    5'd0:    v       = {b[0], b[1], b[2], b[3][7]};
                    5'd1:    v[0]    = b[3][6];
                    5'd2:    v[0]    = b[3][5];
                    default: v = '0;
                endcase
            end
            KIND_PIC_HDR: begin
                case (fid)
                    5'd0:    v[9:0]  = {b[0], b[1][7:6]};
                    5'd1:    v[2:0]  = b[1][5:3];
                    5'd2:    v[15:0] = {b[1][2:0], b[2], b[3][7:3]};
                    5'd3:    v[0]    = b[3][2];
                    5'd4:    v[7:0]  = {b[3][1:0], b[4][7:2]};
                    5'd5:    v[1:0]  = b[3][2] ? b[4][1:0] : b[3][1:0];
                    default: v = '0;
                endcase
            end
            KIND_PIC_EXT: begin
                case (fid)
                    5'd0:    v[3:0]  = b[0][7:4];
                    5'd1:    v[3:0]  = b[0][3:0];
                    5'd2:    v[3:0]  = b[1][7:4];
                    5'd3:    v[3:0]  = b[1][3:0];
                    5'd4:    v[3:0]  = b[2][7:4];
                    5'd5:    v[1:0]  = b[2][3:2];
                    5'd6:    v[1:0]  = b[2][1:0];
                    5'd7:    v[0]    = b[3][7];
                    5'd8:    v[0]    = b[3][6];
                    5'd9:    v[0]    = b[3][5];
                    5'd10:   v[0]    = b[3][4];
                    5'd11:   v[0]    = b[3][3];
                    5'd12:   v[0]    = b[3][2];
                    5'd13:   v[0]    = b[3][1];
                    5'd14:   v[0]    = b[3][0];
                    5'd15:   v[0]    = b[4][7];
                    5'd16:   v[0]    = b[4][6];
                    5'd17:   v[0]    = b[4][5];
                    5'd18:   v[2:0]  = b[4][4:2];
                    5'd19:   v[0]    = b[4][1];
                    5'd20:   v[6:0]  = {b[4][0], b[5][7:2]};
                    5'd21:   v[7:0]  = {b[5][1:0], b[6][7:2]};
                    5'd22:   v[5:0]  = b[4][6] ? {4'd0, b[6][1:0]} : b[4][5:0];
                    default: v = '0;
                endcase
            end
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/vhfe_front.sv
`timescale 1ns / 1ps
// front end: collects header body bytes and hands complete headers to the queue
module vhfe_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  vhfe_pkg::t_in_beat i_data,
    output logic               o_stall,
    input  vhfe_pkg::t_q_status i_q_status,
    output logic               o_push,
    output vhfe_pkg::t_job     o_job
);

    logic       r_active;
    logic [2:0] r_kind;
    logic [2:0] r_count;
    logic [7:0] r_store [0:6];

    logic       n_active;
    logic [2:0] n_kind;
    logic [2:0] n_count;

    logic       accept;
    logic       kind_ok;
    logic       eff_active;
    logic [2:0] eff_kind;
    logic [2:0] eff_count;
    logic       done;

    // accept while the queue has room
    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;

    // a first byte restarts the header
    assign kind_ok    = (i_data.header_kind <= vhfe_pkg::KIND_PIC_EXT);
    assign eff_active = i_data.first_byte ? kind_ok : r_active;
    assign eff_kind   = (i_data.first_byte && kind_ok) ? i_data.header_kind : r_kind;
    assign eff_count  = i_data.first_byte ? 3'd0 : r_count;
    assign done       = vhfe_pkg::f_closes_header(eff_kind, eff_count, i_data.data_byte);

    // complete header goes to the queue
    assign o_push   = accept && eff_active && done;
    always_comb begin
        o_job.kind     = eff_kind;
        o_job.bytes[7] = (eff_count == 3'd7) ? i_data.data_byte : 8'd0;
        for (int i = 0; i < 7; i++) begin
            o_job.bytes[i] = (3'(i) == eff_count) ? i_data.data_byte : r_store[i];
        end
    end

    // next state of the byte collector
    always_comb begin
        n_active = r_active;
        n_kind   = r_kind;
        n_count  = r_count;
        if (accept) begin
            n_kind   = eff_kind;
            n_active = eff_active && !done;
            n_count  = (eff_active && !done) ? eff_count + 3'd1 : 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_kind   <= '0;
            r_count  <= '0;
        end else begin
            r_active <= n_active;
            r_kind   <= n_kind;
            r_count  <= n_count;
        end
    end

    // body byte store
    always_ff @(posedge i_clk) begin
        if (accept && eff_active && !done && eff_count != 3'd7) begin
            r_store[eff_count] <= i_data.data_byte;
        end
    end

endmodule

FILE: sv/vhfe_job_queue.sv
`timescale 1ns / 1ps
// two-entry queue of complete headers between front and back
module vhfe_job_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  vhfe_pkg::t_job      i_job,
    input  logic                i_pop,
    output vhfe_pkg::t_job      o_head,
    output vhfe_pkg::t_q_status o_status
);

    logic [1:0]     r_cnt;
    vhfe_pkg::t_job r_head;
    vhfe_pkg::t_job r_tail;

    logic [1:0]     n_cnt;

    assign o_head         = r_head;
    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // entries shift toward the head
    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            if (i_push && r_cnt == 2'd1) begin
                r_head <= i_job;
            end else begin
                r_head <= r_tail;
            end
            if (i_push && r_cnt == 2'd2) begin
                r_tail <= i_job;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_head <= i_job;
            end else begin
                r_tail <= i_job;
            end
        end
    end

    // queue never overflows or underflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !(i_push && !i_pop))
        else $error("header queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("header queue underflow");

endmodule

FILE: sv/vhfe_back.sv
`timescale 1ns / 1ps
// back end: walks the fields of one header and drives the result register
module vhfe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vhfe_pkg::t_q_status i_q_status,
    input  vhfe_pkg::t_job      i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output vhfe_pkg::t_out_beat o_data
);

    logic                r_busy;
    vhfe_pkg::t_job      r_job;
    logic [4:0]          r_fid;
    logic                r_ovalid;
    vhfe_pkg::t_out_beat r_out;

    logic       n_busy;
    logic [4:0] n_fid;
    logic       n_ovalid;

    logic       out_free;
    logic       emit;
    logic       is_last;
    logic [4:0] last_id;

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    assign out_free = !r_ovalid || !i_stall;
    assign emit     = r_busy && out_free;
    assign last_id  = vhfe_pkg::f_last_id(r_job.kind);
    assign is_last  = (r_fid == last_id);

    // take the next header when idle or as the current one ends
    assign o_pop = !i_q_status.empty && (!r_busy || (emit && is_last));

    // field sequencer
    always_comb begin
        n_busy   = r_busy;
        n_fid    = r_fid;
        n_ovalid = r_ovalid;
        if (emit) begin
            n_ovalid = 1'b1;
            if (is_last) begin
                n_busy = 1'b0;
                n_fid  = '0;
            end else begin
                n_fid = vhfe_pkg::f_next_id(r_job.kind, r_fid, r_job.bytes);
            end
        end else if (out_free) begin
            n_ovalid = 1'b0;
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_fid  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_fid    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_fid    <= n_fid;
            r_ovalid <= n_ovalid;
        end
    end

    // header being worked on
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.result_header_kind <= r_job.kind;
            r_out.field_id           <= r_fid;
            r_out.field_value        <= vhfe_pkg::f_field_value(r_job.kind, r_fid, r_job.bytes);
            r_out.last_field         <= is_last;
        end
    end

    // field index stays within the header's order
    a_fid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_fid <= last_id))
        else $error("field index past end of header");
    // the marked beat carries the final field id of its kind
    a_last_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.last_field) |->
            (r_out.field_id == vhfe_pkg::f_last_id(r_out.result_header_kind)))
        else $error("last field marked on wrong id");

endmodule

FILE: sv/video_header_field_extractor.sv
`timescale 1ns / 1ps
// top level of the video header field extractor
// accepts one header byte per cycle; stall rises only while the two-entry header queue is full
// a closed header passes the queue and the job register before its first field beat, back idle
// throughput: one field beat per cycle from the back end when not stalled, 3 to 23 per header
// reset (synchronous, active low) idles the byte collector, empties the queue, drops any result
module video_header_field_extractor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  vhfe_pkg::t_in_beat  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output vhfe_pkg::t_out_beat o_data
);

    logic                q_push;
    logic                q_pop;
    vhfe_pkg::t_job      q_in;
    vhfe_pkg::t_job      q_head;
    vhfe_pkg::t_q_status q_status;

    // byte collection
    vhfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_stall    (o_stall),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_job      (q_in)
    );

    // header queue
    vhfe_job_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_job    (q_in),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // field emission
    vhfe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

endmodule

FILE: test/video_header_field_extractor_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the video header field extractor: header byte stream in, field beats out
module video_header_field_extractor_tb;

    // stall patterns of the field receiver
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    // expected field beats, worked out from the header bytes that the block accepts
    class field_ledger;
        vhfe_pkg::t_out_beat due_fields[$];
        logic [2:0] cur_kind   = vhfe_pkg::KIND_SEQ_HDR;
        bit         collecting = 1'b0;
        logic [2:0] byte_idx   = '0;
        logic [7:0] body [8];
        logic [4:0] next_id;
        int         fields_matched = 0;
        int         bad_fields     = 0;

        function int pending();
            return due_fields.size();
        endfunction

        // queue one field of the header in progress, ids advance in extraction order
        function void put(input logic [vhfe_pkg::VALUE_W-1:0] value);
            vhfe_pkg::t_out_beat f;
            f.result_header_kind = cur_kind;
            f.field_id           = next_id;
            f.field_value        = value;
            f.last_field         = 1'b0;
            due_fields.push_back(f);
            next_id++;
        endfunction

        // all fields of a finished header, skipped fields jump ahead in the id order
        function void extract_fields();
            logic [7:0] b1, b2, b3, b4, b5, b6, b7, b8;
            vhfe_pkg::t_out_beat f;
            b1 = body[0]; b2 = body[1]; b3 = body[2]; b4 = body[3];
            b5 = body[4]; b6 = body[5]; b7 = body[6]; b8 = body[7];
            next_id = '0;
            case (cur_kind)
                vhfe_pkg::KIND_SEQ_HDR: begin
                    put({b1, b2[7:4]});
                    put({b2[3:0], b3});
                    put(b4[7:4]);
                    put(b4[3:0]);
                    put({b5, b6, b7[7:6]});
                    put(b7[5]);
                    put({b7[4:0], b8[7:3]});
                    put(b8[2]);
                    put(b8[1]);
                    put(b8[0]);
                end
                vhfe_pkg::KIND_SEQ_EXT: begin
                    put(b1[7:4]);
                    put({b1[3:0], b2[7:4]});
                    put(b2[3]);
                    put(b2[2:1]);
                    put({b2[0], b3[7]});
                    put(b3[6:5]);
                    put({b3[4:0], b4[7:1]});
                    put(b4[0]);
                    put(b5);
                    put(b6[7]);
                    put(b6[6:5]);
                    put(b6[4:0]);
                end
                vhfe_pkg::KIND_GOP: begin
                    put({b1, b2, b3, b4[7]});
                    put(b4[6]);
                    put(b4[5]);
                end
                vhfe_pkg::KIND_PIC_HDR: begin
                    put({b1, b2[7:6]});
                    put(b2[5:3]);
                    put({b2[2:0], b3, b4[7:3]});
                    put(b4[2]);
                    if (b4[2]) begin
                        put({b4[1:0], b5[7:2]});
                        put(b5[1:0]);
                    end else begin
                        next_id = vhfe_pkg::FID_PIC_NEXT_SC;
                        put(b4[1:0]);
                    end
                end
                default: begin
                    put(b1[7:4]);
                    put(b1[3:0]);
                    put(b2[7:4]);
                    put(b2[3:0]);
                    put(b3[7:4]);
                    put(b3[3:2]);
                    put(b3[1:0]);
                    // eight single-bit flags, msb first
                    for (int i = 7; i >= 0; i--) begin
                        put(b4[i]);
                    end
                    put(b5[7]);
                    put(b5[6]);
                    if (b5[6]) begin
                        put(b5[5]);
                        put(b5[4:2]);
                        put(b5[1]);
                        put({b5[0], b6[7:2]});
                        put({b6[1:0], b7[7:2]});
                        put(b7[1:0]);
                    end else begin
                        next_id = vhfe_pkg::FID_PCE_NEXT_SC;
                        put(b5[5:0]);
                    end
                end
            endcase
            f = due_fields.pop_back();
            f.last_field = 1'b1;
            due_fields.push_back(f);
        endfunction

        // one accepted header byte
        function void take_byte(input vhfe_pkg::t_in_beat beat);
            logic closes;
            if (beat.first_byte) begin
                byte_idx   = '0;
                collecting = (beat.header_kind <= vhfe_pkg::KIND_PIC_EXT);
                if (collecting) begin
                    cur_kind = beat.header_kind;
                end
            end
            // stray bytes and unknown kinds leave nothing behind
            if (!collecting) begin
                return;
            end
            body[byte_idx] = beat.data_byte;
            case (cur_kind)
                vhfe_pkg::KIND_SEQ_HDR: closes = (byte_idx == vhfe_pkg::LAST_IDX_SEQ_HDR);
                vhfe_pkg::KIND_SEQ_EXT: closes = (byte_idx == vhfe_pkg::LAST_IDX_SEQ_EXT);
                vhfe_pkg::KIND_GOP:     closes = (byte_idx == vhfe_pkg::LAST_IDX_GOP);
                vhfe_pkg::KIND_PIC_HDR:
                    closes = (byte_idx == vhfe_pkg::LAST_IDX_PIC_SHORT && !beat.data_byte[2])
                          || (byte_idx == vhfe_pkg::LAST_IDX_PIC_LONG);
                default:
                    closes = (byte_idx == vhfe_pkg::LAST_IDX_PCE_SHORT && !beat.data_byte[6])
                          || (byte_idx == vhfe_pkg::LAST_IDX_PCE_LONG);
            endcase
            if (!closes) begin
                byte_idx++;
                return;
            end
            collecting = 1'b0;
            byte_idx   = '0;
            extract_fields();
        endfunction

        // one accepted field beat against the oldest expectation
        function void match_field(input vhfe_pkg::t_out_beat got);
            vhfe_pkg::t_out_beat want;
            if (due_fields.size() == 0) begin
                bad_fields++;
                if (bad_fields <= 20) begin
                    $display("%0t: unexpected field beat kind %0d id %0d value 0x%0h last %0b",
                             $time, got.result_header_kind, got.field_id, got.field_value,
                             got.last_field);
                end
                return;
            end
            want = due_fields.pop_front();
            if (got.result_header_kind !== want.result_header_kind
                    || got.field_id !== want.field_id
                    || got.field_value !== want.field_value
                    || got.last_field !== want.last_field) begin
                bad_fields++;
                if (bad_fields <= 20) begin
                    $display("%0t: field mismatch, expected kind %0d id %0d value 0x%0h last %0b",
                             $time, want.result_header_kind, want.field_id, want.field_value,
                             want.last_field);
                    $display("%0t:                 actual kind %0d id %0d value 0x%0h last %0b",
                             $time, got.result_header_kind, got.field_id, got.field_value,
                             got.last_field);
                end
            end else begin
                fields_matched++;
            end
        endfunction
    endclass

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                byte_valid  = 1'b0;
    logic                byte_stall;
    vhfe_pkg::t_in_beat  byte_beat   = '0;
    logic                field_valid;
    logic                field_stall = 1'b0;
    vhfe_pkg::t_out_beat field_beat;

    field_ledger ledger;
    int  burst_left    = 0;
    int  fed_bytes     = 0;
    int  headers_sent  = 0;
    int  headers_cut   = 0;
    bit  squeeze_req   = 1'b0;
    bit  squeeze_done  = 1'b0;

    video_header_field_extractor uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (byte_valid),
        .o_stall (byte_stall),
        .i_data  (byte_beat),
        .o_valid (field_valid),
        .i_stall (field_stall),
        .o_data  (field_beat)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // offer one byte beat and hold it until accepted, bursts mostly separated by idle gaps
    task send_beat(input vhfe_pkg::t_in_beat beat);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        byte_valid <= 1'b1;
        byte_beat  <= beat;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        ledger.take_byte(beat);
        burst_left--;
    endtask

    // first n bytes of a header body, continuation beats carry a random kind
    task send_header(input logic [2:0] kind, input vhfe_pkg::t_hdr_bytes body, input int n);
        vhfe_pkg::t_in_beat beat;
        for (int i = 0; i < n; i++) begin
            beat.header_kind = (i == 0) ? kind : 3'($urandom_range(0, 7));
            beat.first_byte  = (i == 0);
            beat.data_byte   = body[i];
            send_beat(beat);
            fed_bytes++;
        end
        headers_sent++;
    endtask

    // a lone beat: a stray continuation, which the block drops unless a header is still open, or a kind with no meaning
    task send_noise(input logic first);
        vhfe_pkg::t_in_beat beat;
        beat.header_kind = first ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 7));
        beat.first_byte  = first;
        beat.data_byte   = 8'($urandom_range(0, 255));
        send_beat(beat);
    endtask

    // body length that the flag bits of the body call for
    function automatic int body_length(input logic [2:0] kind,
                                       input vhfe_pkg::t_hdr_bytes body);
        case (kind)
            vhfe_pkg::KIND_SEQ_HDR: return vhfe_pkg::LAST_IDX_SEQ_HDR + 1;
            vhfe_pkg::KIND_SEQ_EXT: return vhfe_pkg::LAST_IDX_SEQ_EXT + 1;
            vhfe_pkg::KIND_GOP:     return vhfe_pkg::LAST_IDX_GOP + 1;
            vhfe_pkg::KIND_PIC_HDR:
                return body[3][2] ? vhfe_pkg::LAST_IDX_PIC_LONG + 1
                                  : vhfe_pkg::LAST_IDX_PIC_SHORT + 1;
            default:
                return body[4][6] ? vhfe_pkg::LAST_IDX_PCE_LONG + 1
                                  : vhfe_pkg::LAST_IDX_PCE_SHORT + 1;
        endcase
    endfunction

    // field receiver: checks accepted beats and stalls on its own pattern
    initial begin
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        int          tick;
        logic        hold_next;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(posedge clk);
            if (rst_n && field_valid && !field_stall) begin
                ledger.match_field(field_beat);
            end
            // one long hold-off so the header queue fills and the byte side stalls
            if (squeeze_req && !squeeze_done) begin
                hold_left    = 250;
                squeeze_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                hold_next = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                tick++;
                case (mode)
                    STALL_NONE:     hold_next = 1'b0;
                    STALL_RANDOM:   hold_next = ($urandom_range(0, 9) < 3);
                    STALL_PERIODIC: hold_next = (tick % 3 == 0);
                    default:        hold_next = ($urandom_range(0, 9) < 7);
                endcase
            end
            field_stall <= hold_next;
        end
    end

    // stimulus and end of run
    initial begin
        vhfe_pkg::t_hdr_bytes body;
        logic [2:0] kind;
        int         n;
        int         waited;
        int         leftover;
        ledger = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: all-ones sequence header
        body = '1;
        send_header(vhfe_pkg::KIND_SEQ_HDR, body, 8);
        // partial group of pictures cut by a kind with no meaning, then a stray byte while idle
        body = '0;
        send_header(vhfe_pkg::KIND_GOP, body, 2);
        headers_cut++;
        send_noise(1'b1);
        send_noise(1'b0);
        // all-zero short picture header
        send_header(vhfe_pkg::KIND_PIC_HDR, body, 4);
        // picture coding extension restarted early, then a long all-ones one
        body = {8{8'h5A}};
        send_header(vhfe_pkg::KIND_PIC_EXT, body, 3);
        headers_cut++;
        body = '1;
        send_header(vhfe_pkg::KIND_PIC_EXT, body, 7);

        // random: mostly whole headers, some cut short, some noise
        squeeze_req = 1'b1;
        while (fed_bytes < 110) begin
            kind = 3'($urandom_range(0, 4));
            for (int i = 0; i < 8; i++) begin
                case ($urandom_range(0, 7))
                    0:       body[i] = 8'h00;
                    1:       body[i] = 8'hFF;
                    default: body[i] = 8'($urandom_range(0, 255));
                endcase
            end
            n = body_length(kind, body);
            case ($urandom_range(0, 9))
                7: begin
                    send_header(kind, body, $urandom_range(1, n - 1));
                    headers_cut++;
                end
                8:       send_noise(1'b1);
                9:       send_noise(1'b0);
                default: send_header(kind, body, n);
            endcase
        end
        byte_valid <= 1'b0;

        // drain the remaining fields
        waited = 0;
        while (ledger.pending() > 0 && waited < 50000) begin
            @(posedge clk);
            waited++;
        end
        repeat (30) @(posedge clk);
        leftover = ledger.pending();
        if (leftover > 0) begin
            $display("%0t: %0d expected field beats never arrived", $time, leftover);
        end

        $display("fed %0d header bytes over %0d headers (%0d cut short) plus stray beats",
                 fed_bytes, headers_sent, headers_cut);
        $display("matched %0d field beats, %0d bad, with a long receiver hold-off",
                 ledger.fields_matched, ledger.bad_fields);
        if (ledger.bad_fields == 0 && leftover == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: video_header_field_extractor.f
sv/vhfe_pkg.sv
sv/vhfe_front.sv
sv/vhfe_job_queue.sv
sv/vhfe_back.sv
sv/video_header_field_extractor.sv
test/video_header_field_extractor_tb.sv
